@@ rtl/tsdf_voxel_update_assert.svh @@
// assertion macros used by the checker of the voxel update block
`ifndef TSDF_VOXEL_UPDATE_ASSERT_SVH
`define TSDF_VOXEL_UPDATE_ASSERT_SVH

// same-cycle implication
`define TVU_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tsdf_voxel_update: assertion failed");

// next-cycle implication
`define TVU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tsdf_voxel_update: assertion failed");

`endif

@@ rtl/tvu_pkg.sv @@
`timescale 1ns / 1ps
package tvu_pkg;

  // distance code of a voxel that was never observed
  localparam logic [17:0] NEVER_SEEN = 18'h20000;

  // configuration register indexes
  localparam logic [1:0] CFG_DEPTH_MIN   = 2'd0;
  localparam logic [1:0] CFG_DEPTH_MAX   = 2'd1;
  localparam logic [1:0] CFG_FUSION_MODE = 2'd2;

  localparam logic [15:0] DEPTH_MIN_RST = 16'd410;
  localparam logic [15:0] DEPTH_MAX_RST = 16'd4096;

  // classified request handed from front to back
  typedef struct packed {
    logic        oob;
    logic        free;
    logic        fuse;
    logic        mode;
    logic [17:0] sval;
    logic [14:0] wsmp;
    logic [15:0] label;
  } tvu_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_WB
  } back_state_e;

endpackage

@@ rtl/tvu_front.sv @@
`timescale 1ns / 1ps
module tvu_front #(
  parameter int GRID_DIM = 64,
  parameter int AW       = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [5:0]         voxel_x_i,
  input  logic [5:0]         voxel_y_i,
  input  logic [5:0]         voxel_z_i,
  input  logic               sample_valid_i,
  input  logic [15:0]        observed_depth_i,
  input  logic signed [17:0] voxel_depth_i,
  input  logic [15:0]        truncation_i,
  input  logic [15:0]        semantic_label_i,
  output tvu_pkg::tvu_item_t item_o,
  output logic [AW-1:0]      addr_o
);
  import tvu_pkg::*;

  localparam int GW = $clog2(GRID_DIM) + 1;
  localparam int XW = (GW > 6) ? GW : 6;

  logic [15:0] depth_min_q, depth_max_q;
  logic        mode_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_min_q <= DEPTH_MIN_RST;
      depth_max_q <= DEPTH_MAX_RST;
      mode_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEPTH_MIN:   depth_min_q <= cfg_data_i;
        CFG_DEPTH_MAX:   depth_max_q <= cfg_data_i;
        CFG_FUSION_MODE: mode_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [18:0] s;
  logic signed [19:0] s_plus_t;
  logic [18:0]        five_d;
  logic               acc;
  logic [17:0]        s0, s1;

  // sample classification
  always_comb begin
    s        = $signed({3'b000, observed_depth_i}) - $signed({voxel_depth_i[17], voxel_depth_i});
    s_plus_t = $signed({s[18], s}) + $signed({4'b0000, truncation_i});
    acc      = sample_valid_i && (observed_depth_i >= depth_min_q) &&
               (observed_depth_i <= depth_max_q);
    five_d   = {3'b000, observed_depth_i} + {1'b0, observed_depth_i, 2'b00};

    // clamp to truncation for blending
    if (s > $signed({3'b000, truncation_i})) s0 = {2'b00, truncation_i};
    else                                     s0 = s[17:0];
    // saturate for closest surface
    if (s > 19'sd131071) s1 = 18'h1FFFF;
    else                 s1 = s[17:0];

    item_o.oob   = (XW'(voxel_x_i) >= XW'(GRID_DIM)) || (XW'(voxel_y_i) >= XW'(GRID_DIM)) ||
                   (XW'(voxel_z_i) >= XW'(GRID_DIM));
    item_o.free  = acc && (s > 19'sd0);
    item_o.fuse  = acc && (s_plus_t > 20'sd0);
    item_o.mode  = mode_q;
    item_o.sval  = mode_q ? s1 : s0;
    item_o.wsmp  = (five_d >= 19'd16384) ? 15'd4096 : 15'(19'd20480 - five_d);
    item_o.label = semantic_label_i;
  end

  // linear voxel address
  assign addr_o = AW'(voxel_x_i) + AW'(GRID_DIM) * AW'(voxel_y_i) +
                  AW'(GRID_DIM * GRID_DIM) * AW'(voxel_z_i);

endmodule

@@ rtl/tvu_fifo.sv @@
`timescale 1ns / 1ps
module tvu_fifo #(
  parameter int DW = 72
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);
  logic [DW-1:0] buf_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  // two-entry request queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = buf_q[rd_ptr_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);

endmodule

@@ rtl/tvu_back.sv @@
`timescale 1ns / 1ps
module tvu_back #(
  parameter int AW    = 18,
  parameter int FCB   = 16,
  parameter int DEPTH = 262144
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tvu_pkg::tvu_item_t item_i,
  input  logic [AW-1:0]      addr_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               was_updated_o,
  output logic [17:0]        new_distance_o,
  output logic [7:0]         new_weight_o,
  output logic [15:0]        new_free_count_o,
  output logic [15:0]        new_label_o
);
  import tvu_pkg::*;

  localparam int MW = 18 + 8 + FCB + 16;
  localparam int FW = (FCB > 16) ? FCB : 16;
  localparam int QW = 18;

  back_state_e state_q, state_d;

  logic [MW-1:0]  mem [DEPTH];
  logic [MW-1:0]  rd_q;
  tvu_item_t      item_q;
  logic [AW-1:0]  addr_q, clr_q;
  logic [17:0]    res_d_q, res_d_d;
  logic [7:0]     res_w_q, res_w_d;
  logic [FCB-1:0] res_fc_q;
  logic [15:0]    res_lbl_q, res_lbl_d;
  logic           div_q, neg_q;
  logic signed [26:0] p1_q;
  logic signed [33:0] p2_q;
  logic [21:0]    rem_q, dv_q;
  logic [17:0]    nlo_q, quo_q;
  logic [4:0]     cnt_q;

  logic [17:0]    old_d;
  logic [7:0]     old_w;
  logic [FCB-1:0] old_fc, fc_new;
  logic [15:0]    old_lbl;
  logic           never, take, need_div, last_clr, last_div, fire;
  logic [17:0]    s_abs, o_abs, new_d;
  logic [8:0]     wsum;
  logic [7:0]     w0;
  logic signed [39:0] num;
  logic [39:0]    num_abs, n2;
  logic [20:0]    den;
  logic [22:0]    trial;
  logic           qbit;
  logic           mem_we, rd_en;
  logic [AW-1:0]  mem_wa;
  logic [MW-1:0]  mem_wd;
  logic [FW-1:0]  fcw;

  // stored voxel fields
  assign old_d   = rd_q[MW-1 -: 18];
  assign old_w   = rd_q[MW-19 -: 8];
  assign old_fc  = rd_q[16 +: FCB];
  assign old_lbl = rd_q[15:0];

  // per-voxel update logic
  always_comb begin
    never    = (old_d == NEVER_SEEN);
    fc_new   = (item_q.free && old_fc != {FCB{1'b1}}) ? old_fc + 1'b1 : old_fc;
    s_abs    = item_q.sval[17] ? 18'(-item_q.sval) : item_q.sval;
    o_abs    = old_d[17] ? 18'(-old_d) : old_d;
    take     = never || ((s_abs <= o_abs) && (!item_q.sval[17] || old_d[17] || old_d == 18'd0));
    wsum     = {1'b0, old_w} + {6'b0, item_q.wsmp[14:12]};
    w0       = wsum[8] ? 8'hFF : wsum[7:0];
    need_div = item_q.fuse && !item_q.mode && !never;
    last_clr = (clr_q == AW'(DEPTH - 1));
    last_div = (cnt_q == 5'(QW - 1));
    fire     = !out_valid_o || !out_stall_i;
  end

  // voxel contents after fusion, before any division
  always_comb begin
    res_d_d   = old_d;
    res_w_d   = old_w;
    res_lbl_d = old_lbl;
    if (item_q.fuse) begin
      if (item_q.mode) begin
        if (take) begin
          res_d_d   = item_q.sval;
          res_w_d   = 8'd1;
          res_lbl_d = item_q.label;
        end
      end else begin
        res_w_d = w0;
        if (never) res_d_d = item_q.sval;
      end
    end
  end

  // blend numerator and denominator
  always_comb begin
    num     = (40'(p1_q) <<< 12) + 40'(p2_q);
    num_abs = num[39] ? 40'(-num) : 40'(num);
    den     = {1'b0, old_w, 12'b0} + {6'b0, item_q.wsmp};
    n2      = {num_abs[38:0], 1'b0} + {19'b0, den};
    trial   = {rem_q, nlo_q[17]};
    qbit    = (trial >= {1'b0, dv_q});
    new_d   = div_q ? (neg_q ? 18'(-quo_q) : quo_q) : res_d_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (last_clr) state_d = ST_IDLE;
      ST_IDLE:  if (!empty_i) state_d = ST_CALC;
      ST_CALC:  state_d = need_div ? ST_MUL : ST_WB;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (last_div) state_d = ST_WB;
      ST_WB:    if (fire) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = addr_q;
    mem_wd     = {new_d, res_w_q, res_fc_q, res_lbl_q};
    rd_en      = 1'b0;
    pop_o      = 1'b0;
    clearing_o = (state_q == ST_CLEAR);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = {NEVER_SEEN, 8'd0, {FCB{1'b0}}, 16'd0};
      end
      ST_IDLE: begin
        pop_o = !empty_i;
        rd_en = !empty_i;
      end
      ST_WB: mem_we = fire && !item_q.oob;
      default: ;
    endcase
  end

  // voxel memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  rd_q <= mem[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_q <= item_i;
        addr_q <= addr_i;
      end
      ST_CALC: begin
        res_d_q   <= res_d_d;
        res_w_q   <= res_w_d;
        res_fc_q  <= fc_new;
        res_lbl_q <= res_lbl_d;
        div_q     <= need_div;
        p1_q      <= $signed(old_d) * $signed({1'b0, old_w});
        p2_q      <= $signed(item_q.sval) * $signed({1'b0, item_q.wsmp});
      end
      ST_MUL: begin
        rem_q <= n2[39:18];
        nlo_q <= n2[17:0];
        dv_q  <= {den, 1'b0};
        neg_q <= num[39];
        quo_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= qbit ? 22'(trial - {1'b0, dv_q}) : trial[21:0];
        quo_q <= {quo_q[16:0], qbit};
        nlo_q <= {nlo_q[16:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_WB && fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign fcw = FW'(res_fc_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WB && fire) begin
      if (item_q.oob) begin
        was_updated_o    <= 1'b0;
        new_distance_o   <= NEVER_SEEN;
        new_weight_o     <= 8'd0;
        new_free_count_o <= 16'd0;
        new_label_o      <= 16'd0;
      end else begin
        was_updated_o    <= (new_d != old_d) || (res_w_q != old_w);
        new_distance_o   <= new_d;
        new_weight_o     <= res_w_q;
        new_free_count_o <= (fcw > FW'(16'hFFFF)) ? 16'hFFFF : fcw[15:0];
        new_label_o      <= res_lbl_q;
      end
    end
  end

endmodule

@@ rtl/tsdf_voxel_update.sv @@
`timescale 1ns / 1ps
// Fuses one depth sample into one voxel of a GRID_DIM^3 truncated signed distance grid per
// request and returns the voxel's contents after the update. After reset the block runs a
// clearing pass over all GRID_DIM^3 voxels with in_stall_o high. A request then goes
// through the voxel engine (memory read, update, write-back); a weighted-average blend
// into an already observed voxel also needs the restoring divider between update and
// write-back, which retires one quotient bit per cycle over 18 bits. A two-entry queue in
// front and an output register behind let requests arrive while a result waits.
module tsdf_voxel_update #(
  parameter int GRID_DIM        = 64,
  parameter int FREE_COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [5:0]         voxel_x_i,
  input  logic [5:0]         voxel_y_i,
  input  logic [5:0]         voxel_z_i,
  input  logic               sample_valid_i,
  input  logic [15:0]        observed_depth_i,
  input  logic signed [17:0] voxel_depth_i,
  input  logic [15:0]        truncation_i,
  input  logic [15:0]        semantic_label_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               was_updated_o,
  output logic signed [17:0] new_distance_o,
  output logic [7:0]         new_weight_o,
  output logic [15:0]        new_free_count_o,
  output logic [15:0]        new_label_o
);
  import tvu_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $bits(tvu_item_t);

  tvu_item_t         f_item, b_item;
  logic [AW-1:0]     f_addr, b_addr;
  logic              full, empty, pop, clearing, push;
  logic [17:0]       back_dist;

  // request front end
  tvu_front #(.GRID_DIM(GRID_DIM), .AW(AW)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .voxel_x_i, .voxel_y_i, .voxel_z_i, .sample_valid_i, .observed_depth_i,
    .voxel_depth_i, .truncation_i, .semantic_label_i,
    .item_o(f_item), .addr_o(f_addr)
  );

  assign in_stall_o = full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  // request queue
  tvu_fifo #(.DW(IW + AW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i({f_addr, f_item}), .full_o(full),
    .pop_i(pop), .data_o({b_addr, b_item}), .empty_o(empty)
  );

  // voxel engine
  tvu_back #(.AW(AW), .FCB(FREE_COUNT_BITS), .DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni,
    .item_i(b_item), .addr_i(b_addr), .empty_i(empty), .pop_o(pop),
    .clearing_o(clearing), .out_valid_o, .out_stall_i, .was_updated_o,
    .new_distance_o(back_dist), .new_weight_o, .new_free_count_o, .new_label_o
  );

  assign new_distance_o = $signed(back_dist);

endmodule

@@ rtl/tvu_checker.sv @@
`timescale 1ns / 1ps
`include "tsdf_voxel_update_assert.svh"
module tvu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               was_updated_o,
  input logic signed [17:0] new_distance_o,
  input logic [7:0]         new_weight_o
);
  // stalled result holds
  `TVU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(new_distance_o) && $stable(new_weight_o))
  // an update always leaves an observed distance
  `TVU_ASSERT_IMPL(a_upd_seen, clk_i, rst_ni, out_valid_o && was_updated_o, new_distance_o != -18'sd131072)
  // an update always leaves a nonzero weight
  `TVU_ASSERT_IMPL(a_upd_wgt, clk_i, rst_ni, out_valid_o && was_updated_o, new_weight_o != 8'd0)
  // unobserved voxel carries no weight
  `TVU_ASSERT_IMPL(a_unseen_wgt, clk_i, rst_ni, out_valid_o && new_distance_o == -18'sd131072, new_weight_o == 8'd0)
endmodule

bind tsdf_voxel_update tvu_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .was_updated_o, .new_distance_o, .new_weight_o
);

@@ bench/tb_tsdf_voxel_update.sv @@
`timescale 1ns / 1ps
module tb_tsdf_voxel_update;
  import tvu_pkg::*;

  localparam int           CYCLE_LIMIT  = 3000000;
  localparam int           DRAIN_CYCLES = 40;
  localparam int           PHASE_ITEMS  = 545;
  localparam int           POOL_SIZE    = 8;
  localparam logic [1:0]   CFG_SPARE    = 2'd3;
  localparam logic [15:0]  MODE_AVERAGE = 16'd0;
  localparam logic [15:0]  MODE_CLOSEST = 16'd1;
  localparam longint       UNSEEN_DIST  = -131072;

  typedef struct {
    logic [5:0]         x, y, z;
    logic               sample_ok;
    logic [15:0]        depth;
    logic signed [17:0] vox_depth;
    logic [15:0]        trunc;
    logic [15:0]        label;
  } voxel_req_t;

  typedef struct {
    logic               updated;
    logic signed [17:0] dist_val;
    logic [7:0]         weight;
    logic [15:0]        free_cnt;
    logic [15:0]        label;
  } voxel_res_t;

  // voxel grid shadow and queue of expected voxel contents
  class voxel_scoreboard;
    longint     dist_mem[int];
    int         weight_mem[int];
    int         free_mem[int];
    int         label_mem[int];
    longint     win_lo = 410;
    longint     win_hi = 4096;
    int         mode = 0;
    voxel_res_t expected_q[$];
    int         errors = 0;
    int         checked = 0;
    int         fused = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_DEPTH_MIN:   win_lo = data;
        CFG_DEPTH_MAX:   win_hi = data;
        CFG_FUSION_MODE: mode = data[0];
        default: ;
      endcase
    endfunction

    function longint round_div(longint num, longint den);
      longint mag;
      mag = ((num < 0 ? -num : num) * 2 + den) / (2 * den);
      return num < 0 ? -mag : mag;
    endfunction

    function void note_request(voxel_req_t r);
      int         key;
      longint     old_d, new_d, s, d, zd, t, w8, nw, abs_s, abs_o;
      int         old_w, new_w, fc, lbl;
      voxel_res_t res;
      key = {r.z, r.y, r.x};
      old_d = dist_mem.exists(key) ? dist_mem[key] : UNSEEN_DIST;
      old_w = weight_mem.exists(key) ? weight_mem[key] : 0;
      fc = free_mem.exists(key) ? free_mem[key] : 0;
      lbl = label_mem.exists(key) ? label_mem[key] : 0;
      new_d = old_d;
      new_w = old_w;
      d = r.depth;
      zd = r.vox_depth;
      t = r.trunc;
      if (r.sample_ok && d >= win_lo && d <= win_hi) begin
        s = d - zd;
        if (zd < d && fc < 65535) fc++;
        if (s > -t) begin
          fused++;
          if (mode == 0) begin
            if (s > t) s = t;
            w8 = 20480 - 5 * d;
            if (w8 < 4096) w8 = 4096;
            if (old_d == UNSEEN_DIST) new_d = s;
            else new_d = round_div(old_d * old_w * 4096 + s * w8, old_w * 4096 + w8);
            nw = old_w + w8 / 4096;
            new_w = int'(nw > 255 ? 255 : nw);
          end else begin
            if (s > 131071) s = 131071;
            abs_s = s < 0 ? -s : s;
            abs_o = old_d < 0 ? -old_d : old_d;
            if (old_d == UNSEEN_DIST || (abs_s <= abs_o && (s >= 0 || old_d <= 0))) begin
              new_d = s;
              new_w = 1;
              lbl = r.label;
            end
          end
        end
      end
      dist_mem[key] = new_d;
      weight_mem[key] = new_w;
      free_mem[key] = fc;
      label_mem[key] = lbl;
      res.updated = (new_d != old_d) || (new_w != old_w);
      res.dist_val = new_d[17:0];
      res.weight = new_w[7:0];
      res.free_cnt = fc[15:0];
      res.label = lbl[15:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(voxel_res_t got);
      voxel_res_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.updated !== exp_r.updated) begin
        $error("was_updated expected %0d got %0d", exp_r.updated, got.updated);
        errors++;
      end
      if (got.dist_val !== exp_r.dist_val) begin
        $error("new_distance expected %0d got %0d", exp_r.dist_val, got.dist_val);
        errors++;
      end
      if (got.weight !== exp_r.weight) begin
        $error("new_weight expected %0d got %0d", exp_r.weight, got.weight);
        errors++;
      end
      if (got.free_cnt !== exp_r.free_cnt) begin
        $error("new_free_count expected %0d got %0d", exp_r.free_cnt, got.free_cnt);
        errors++;
      end
      if (got.label !== exp_r.label) begin
        $error("new_label expected %0d got %0d", exp_r.label, got.label);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [5:0]         voxel_x_i = '0;
  logic [5:0]         voxel_y_i = '0;
  logic [5:0]         voxel_z_i = '0;
  logic               sample_valid_i = 1'b0;
  logic [15:0]        observed_depth_i = '0;
  logic signed [17:0] voxel_depth_i = '0;
  logic [15:0]        truncation_i = '0;
  logic [15:0]        semantic_label_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               was_updated_o;
  logic signed [17:0] new_distance_o;
  logic [7:0]         new_weight_o;
  logic [15:0]        new_free_count_o;
  logic [15:0]        new_label_o;

  voxel_scoreboard sb = new();
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              cycles = 0;
  logic [17:0]     pool[POOL_SIZE];

  tsdf_voxel_update dut (.*);

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_idle_pct);
  end

  // result checking
  always @(posedge clk_i) begin
    voxel_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.updated = was_updated_o;
      got.dist_val = new_distance_o;
      got.weight = new_weight_o;
      got.free_cnt = new_free_count_o;
      got.label = new_label_o;
      sb.check_result(got);
    end
  end

  // drive one request and wait for its acceptance
  task automatic send_request(voxel_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    voxel_x_i = r.x;
    voxel_y_i = r.y;
    voxel_z_i = r.z;
    sample_valid_i = r.sample_ok;
    observed_depth_i = r.depth;
    voxel_depth_i = r.vox_depth;
    truncation_i = r.trunc;
    semantic_label_i = r.label;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  // wait until every result is back and the engine has settled
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_window(logic [15:0] lo, logic [15:0] hi, logic [15:0] mode);
    write_reg(CFG_DEPTH_MIN, lo);
    write_reg(CFG_DEPTH_MAX, hi);
    write_reg(CFG_FUSION_MODE, mode);
  endtask

  function automatic voxel_req_t make_req(int x, int y, int z, bit ok, int d, int zd,
                                          int t, int lbl);
    voxel_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.sample_ok = ok;
    r.depth = d;
    r.vox_depth = zd;
    r.trunc = t;
    r.label = lbl;
    return r;
  endfunction

  // mostly pooled voxels with depths in the window, sometimes pure noise
  function automatic voxel_req_t random_req();
    voxel_req_t r;
    int         d, t, zd;
    logic [17:0] key;
    if ($urandom_range(99) < 25) begin
      r = make_req($urandom_range(63), $urandom_range(63), $urandom_range(63),
                   $urandom_range(1), $urandom_range(65535), 0,
                   $urandom_range(65535), $urandom_range(65535));
      r.vox_depth = $urandom();
      return r;
    end
    key = pool[$urandom_range(POOL_SIZE - 1)];
    d = $urandom_range(sb.win_hi, sb.win_lo);
    t = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(2000);
    zd = d + $signed($urandom_range(2 * t + 200)) - t - 100;
    if (zd > 131071) zd = 131071;
    if (zd < -131072) zd = -131072;
    r = make_req(key[5:0], key[11:6], key[17:12], $urandom_range(19) != 0, d, zd, t,
                 $urandom_range(65535));
    return r;
  endfunction

  task automatic random_phase(int s_pct, int r_pct, logic [15:0] lo, logic [15:0] hi,
                              logic [15:0] mode);
    set_window(lo, hi, mode);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) drain();
      send_request(random_req());
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom();
    pool[0] = '0;
    pool[1] = '1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: defaults, mode 0
    send_request(make_req(1, 2, 3, 0, 1000, 500, 300, 7));
    send_request(make_req(1, 2, 3, 1, 409, 200, 300, 7));
    send_request(make_req(1, 2, 3, 1, 4097, 200, 300, 7));
    send_request(make_req(1, 2, 3, 1, 410, 300, 300, 7));
    send_request(make_req(1, 2, 3, 1, 4096, 4000, 300, 7));
    send_request(make_req(1, 2, 3, 1, 2000, 2900, 300, 7));
    send_request(make_req(63, 63, 63, 1, 3000, -131072, 65535, 16'hffff));
    send_request(make_req(63, 63, 63, 1, 3000, 131071, 0, 0));
    send_request(make_req(0, 0, 0, 1, 1000, 1000, 0, 0));
    send_request(make_req(0, 0, 0, 1, 1000, 1500, 600, 0));
    drain();
    // full window, depth zero for the largest sample weight
    set_window(16'd0, 16'hffff, MODE_AVERAGE);
    write_reg(CFG_SPARE, 16'hffff);
    send_request(make_req(5, 5, 5, 1, 0, -100, 50, 3));
    send_request(make_req(5, 5, 5, 1, 65535, 65000, 800, 3));
    drain();
    // empty window rejects everything
    set_window(16'd5000, 16'd100, MODE_AVERAGE);
    send_request(make_req(5, 5, 5, 1, 1000, 900, 500, 3));
    drain();
    // closest surface with labels
    set_window(16'd0, 16'hffff, MODE_CLOSEST);
    send_request(make_req(9, 9, 9, 1, 2000, 1500, 1000, 11));
    send_request(make_req(9, 9, 9, 1, 2000, 1800, 1000, 12));
    send_request(make_req(9, 9, 9, 1, 2000, 1000, 2000, 13));
    send_request(make_req(9, 9, 9, 1, 2000, 2100, 1000, 14));
    send_request(make_req(9, 9, 9, 1, 2000, 1800, 1000, 15));
    send_request(make_req(10, 9, 9, 1, 65535, -131072, 10, 16));
    send_request(make_req(10, 9, 9, 1, 100, 90, 10, 17));
    drain();

    random_phase(23, 50, 16'd200, 16'd8000, MODE_AVERAGE);
    random_phase(50, 23, 16'd0, 16'hffff, MODE_CLOSEST);
    random_phase(0, 0, 16'd410, 16'd4096, MODE_AVERAGE);

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("checked %0d voxel results, %0d fused samples, both fusion modes,",
             sb.checked, sb.fused);
    $display("depth windows full, default, narrow and empty, under varied stalls");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ tsdf_voxel_update.f @@
+incdir+rtl
rtl/tvu_pkg.sv
rtl/tvu_front.sv
rtl/tvu_fifo.sv
rtl/tvu_back.sv
rtl/tsdf_voxel_update.sv
rtl/tvu_checker.sv
bench/tb_tsdf_voxel_update.sv
